[rtl/core/cltok_pkg.sv]
package cltok_pkg;

    localparam int unsigned MAX_FIELDS_DEFAULT = 64;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned COUNT_W = 7;
    localparam logic [COUNT_W-1:0] TABLE_FIELD_COUNT_RESET = 7'd64;

    localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_EOF  = 2'd1,
        KIND_EOL  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        CLS_NONE   = 2'd0,
        CLS_QUOTE  = 2'd1,
        CLS_BSLASH = 2'd2,
        CLS_OTHER  = 2'd3
    } class_t;

    typedef struct packed {
        logic               emit;
        kind_t              kind;
        logic [BYTE_W-1:0]  data;
        logic [COUNT_W-1:0] idx;
        logic               matched;
    } result_t;

endpackage

[rtl/core/cltok_core.sv]
module cltok_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              fire,
    input  logic [cltok_pkg::BYTE_W-1:0]      text_byte,
    input  logic [cltok_pkg::COUNT_W-1:0]     field_limit,
    output cltok_pkg::result_t                res
);

    logic                          quote_reg;
    logic                          quote_next;
    cltok_pkg::class_t             class_reg;
    cltok_pkg::class_t             class_next;
    logic                          skip_reg;
    logic                          skip_next;
    logic [cltok_pkg::COUNT_W-1:0] stored_reg;
    logic [cltok_pkg::COUNT_W-1:0] stored_next;
    logic                          escaped;

    always_comb
    begin
        quote_next  = quote_reg;
        class_next  = class_reg;
        skip_next   = skip_reg;
        stored_next = stored_reg;
        escaped     = 1'b0;
        res.emit    = 1'b0;
        res.kind    = cltok_pkg::KIND_DATA;
        res.data    = '0;
        res.idx     = stored_reg;
        res.matched = (stored_reg < field_limit);

        if (skip_reg)
        begin
            skip_next = 1'b0;
        end
        else
        begin
            case (text_byte)
                cltok_pkg::CH_QUOTE:
                begin
                    if (class_reg == cltok_pkg::CLS_BSLASH ||
                        (class_reg == cltok_pkg::CLS_QUOTE && !quote_reg))
                    begin
                        res.emit = 1'b1;
                        res.data = text_byte;
                        escaped  = 1'b1;
                        if (class_reg == cltok_pkg::CLS_QUOTE)
                        begin
                            quote_next = 1'b1;
                        end
                    end
                    else
                    begin
                        quote_next = !quote_reg;
                    end
                end
                cltok_pkg::CH_BSLASH:
                begin
                    if (class_reg == cltok_pkg::CLS_BSLASH)
                    begin
                        res.emit = 1'b1;
                        res.data = text_byte;
                        escaped  = 1'b1;
                    end
                end
                cltok_pkg::CH_CR, cltok_pkg::CH_LF:
                begin
                    res.emit = 1'b1;
                    if (quote_reg)
                    begin
                        res.data = text_byte;
                    end
                    else
                    begin
                        res.kind = cltok_pkg::KIND_EOL;
                    end
                end
                cltok_pkg::CH_COMMA:
                begin
                    res.emit = 1'b1;
                    if (quote_reg)
                    begin
                        res.data = text_byte;
                    end
                    else
                    begin
                        res.kind = cltok_pkg::KIND_EOF;
                    end
                end
                default:
                begin
                    res.emit = 1'b1;
                    res.data = text_byte;
                end
            endcase

            if (escaped)
            begin
                class_next = cltok_pkg::CLS_NONE;
            end
            else if (text_byte == cltok_pkg::CH_QUOTE)
            begin
                class_next = cltok_pkg::CLS_QUOTE;
            end
            else if (text_byte == cltok_pkg::CH_BSLASH)
            begin
                class_next = cltok_pkg::CLS_BSLASH;
            end
            else
            begin
                class_next = cltok_pkg::CLS_OTHER;
            end

            if (res.kind == cltok_pkg::KIND_EOF && res.matched)
            begin
                stored_next = stored_reg + 1'b1;
            end

            if (res.kind == cltok_pkg::KIND_EOL)
            begin
                skip_next   = (text_byte == cltok_pkg::CH_CR);
                quote_next  = 1'b0;
                class_next  = cltok_pkg::CLS_NONE;
                stored_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quote_reg  <= 1'b0;
            class_reg  <= cltok_pkg::CLS_NONE;
            skip_reg   <= 1'b0;
            stored_reg <= '0;
        end
        else if (fire)
        begin
            quote_reg  <= quote_next;
            class_reg  <= class_next;
            skip_reg   <= skip_next;
            stored_reg <= stored_next;
        end
    end

endmodule

[rtl/core/cltok_out_reg.sv]
module cltok_out_reg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  cltok_pkg::result_t            res,
    output logic                          can_load,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    token_kind,
    output logic [cltok_pkg::BYTE_W-1:0]  data_byte,
    output logic [cltok_pkg::COUNT_W-1:0] field_index,
    output logic                          field_matched
);

    logic               valid_reg;
    logic               valid_next;
    cltok_pkg::result_t res_reg;

    assign can_load = !valid_reg || out_ready;

    always_comb
    begin
        if (load)
        begin
            valid_next = res.emit;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && res.emit)
        begin
            res_reg <= res;
        end
    end

    assign out_valid     = valid_reg;
    assign token_kind    = res_reg.kind;
    assign data_byte     = res_reg.data;
    assign field_index   = res_reg.idx;
    assign field_matched = res_reg.matched;

endmodule

[rtl/core/csv_line_tokenizer_top.sv]
// csv line tokenizer
// input channel: in_valid/in_ready with text_byte, one raw byte per transfer
// output channel: out_valid/out_ready with token_kind (0 data byte,
//   1 end of field, 2 end of line), data_byte, field_index, field_matched
// config channel: cfg_valid/cfg_ready with cfg_data, the table field count;
//   cfg_ready is always high, write only while no byte is in flight
// a byte lands in an input register, is decoded against the quote, class,
//   skip and field-count state once the output register can take it, and
//   its result (if any) lands in the output register
// throughput: one byte per cycle while the receiver keeps out_ready high
// bytes that give no result (opening or closing quotes, lone backslash, byte
//   after a line-ending cr) just update state and leave no output transfer
// when the receiver stalls, a result waits in the output register, one more
//   byte is held in the input register, then in_ready drops
// reset clears all state, empties both registers and sets the count to 64
module csv_line_tokenizer_top #(
    parameter int unsigned MAX_FIELDS = cltok_pkg::MAX_FIELDS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [cltok_pkg::BYTE_W-1:0]  text_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    token_kind,
    output logic [cltok_pkg::BYTE_W-1:0]  data_byte,
    output logic [cltok_pkg::COUNT_W-1:0] field_index,
    output logic                          field_matched,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cltok_pkg::COUNT_W-1:0] cfg_data
);

    localparam int unsigned CountMax = (1 << cltok_pkg::COUNT_W) - 1;
    localparam int unsigned CountCap = (MAX_FIELDS > CountMax) ? CountMax : MAX_FIELDS;

    logic [cltok_pkg::COUNT_W-1:0] limit_reg;
    logic [cltok_pkg::COUNT_W-1:0] field_limit;
    logic                          byte_valid_reg;
    logic [cltok_pkg::BYTE_W-1:0]  byte_reg;
    logic                          can_load;
    logic                          advance;
    cltok_pkg::result_t            res;

    assign cfg_ready   = 1'b1;
    assign field_limit = (limit_reg > cltok_pkg::COUNT_W'(CountCap))
                       ? cltok_pkg::COUNT_W'(CountCap) : limit_reg;

    assign advance  = byte_valid_reg && can_load;
    assign in_ready = !byte_valid_reg || can_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= cltok_pkg::TABLE_FIELD_COUNT_RESET;
        end
        else if (cfg_valid)
        begin
            limit_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            byte_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= text_byte;
        end
    end

    cltok_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (advance),
        .text_byte   (byte_reg),
        .field_limit (field_limit),
        .res         (res)
    );

    cltok_out_reg u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (advance),
        .res           (res),
        .can_load      (can_load),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .token_kind    (token_kind),
        .data_byte     (data_byte),
        .field_index   (field_index),
        .field_matched (field_matched)
    );

endmodule
